### design/rgbfe_pkg.sv
// ----------------------------------------------------------------------------
// rgbfe_pkg
// Shared widths, codes and the divider request/response types for the
// RGB LED fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbfe_pkg;

    localparam int CH_N       = 3;
    localparam int LVL_W      = 8;
    localparam int FLD_W      = 16;
    localparam int CH_IDX_W   = 2;

    // serial divider: dividend is left aligned in DIV_W bits
    localparam int DIV_W      = 26;
    localparam int DIV_REM_W  = 16;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] STEPS_ITERS = 5'd26;
    localparam logic [DIV_CNT_W-1:0] IVAL_ITERS  = 5'd18;
    localparam int IVAL_NUM_W = 18;

    // duty mapping
    localparam int PROD_W     = 24;
    localparam int Q0_W       = 17;
    localparam int MUL_CNT_W  = 3;

    localparam logic CMD_SET_COLOUR = 1'b0;
    localparam logic CMD_TICK       = 1'b1;

    localparam logic CFG_PWM_FREQUENCY = 1'b0;
    localparam logic CFG_PWM_PERIOD    = 1'b1;

    localparam logic [FLD_W-1:0] PWM_FREQUENCY_RST = 16'd1000;
    localparam logic [FLD_W-1:0] PWM_PERIOD_RST    = 16'd49999;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### design/rgbfe_serdiv.sv
// ----------------------------------------------------------------------------
// rgbfe_serdiv
// Restoring divider, one quotient bit per cycle. The dividend arrives left
// aligned; after the requested number of iterations the quotient sits in the
// low bits of the shift register and done pulses for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbfe_serdiv
    import rgbfe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     dq_reg, dq_next;
    logic [DIV_REM_W-1:0] divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_REM_W:0]   trial;
    logic [DIV_REM_W:0]   trial_sub;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, divisor_reg};
        fits      = (trial >= {1'b0, divisor_reg});

        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;

        if (req.start)
        begin
            rem_next     = '0;
            dq_next      = req.dividend;
            divisor_next = req.divisor;
            cnt_next     = req.iters;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            dq_next  = {dq_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

`default_nettype wire

### design/rgb_led_fade_engine.sv
// ----------------------------------------------------------------------------
// rgb_led_fade_engine
// Three-channel linear LED fader: stores a colour target, steps each channel
// toward it on fade ticks and maps the levels to PWM duties.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  item      item_valid / item_ready    cmd, target_red/green/blue, fade_time_ms
//  result    result_valid / result_ready duty_*, current_*, fading
//  config    cfg_we (no wait)           cfg_index, cfg_data
//
//  One item at a time. Every item ends with the duty mapping; a set-colour
//  item first runs a serial divide for the step count, and the first tick of a
//  fade first runs at most one serial divide per channel for the intervals.
//  The duty mapping is a bit-serial multiply plus divide-by-255 in S_D255A and
//  S_D255B. A finished result waits in the output register while the
//  next item is accepted; a stalled output holds the engine in its last state.
//  Reset clears all levels, goals and counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_fade_engine
    import rgbfe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [FLD_W-1:0] cfg_data,

    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire logic             cmd,
    input  wire logic [LVL_W-1:0] target_red,
    input  wire logic [LVL_W-1:0] target_green,
    input  wire logic [LVL_W-1:0] target_blue,
    input  wire logic [FLD_W-1:0] fade_time_ms,

    output logic                  result_valid,
    input  wire logic             result_ready,
    output logic [FLD_W-1:0]      duty_red,
    output logic [FLD_W-1:0]      duty_green,
    output logic [FLD_W-1:0]      duty_blue,
    output logic [LVL_W-1:0]      current_red,
    output logic [LVL_W-1:0]      current_green,
    output logic [LVL_W-1:0]      current_blue,
    output logic                  fading
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_STEPS    = 10'b00_0000_0010,
        S_IVAL_SET = 10'b00_0000_0100,
        S_IVAL_DIV = 10'b00_0000_1000,
        S_TICK     = 10'b00_0001_0000,
        S_MUL_LOAD = 10'b00_0010_0000,
        S_MUL      = 10'b00_0100_0000,
        S_D255A    = 10'b00_1000_0000,
        S_D255B    = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(CH_N - 1);

    state_t state_reg, state_next;

    logic [FLD_W-1:0] freq_reg, freq_next;
    logic [FLD_W-1:0] period_reg, period_next;

    logic [LVL_W-1:0] level_now_reg  [CH_N];
    logic [LVL_W-1:0] level_now_next [CH_N];
    logic [LVL_W-1:0] level_goal_reg [CH_N];
    logic [LVL_W-1:0] level_goal_next[CH_N];
    logic [FLD_W-1:0] ival_reg       [CH_N];
    logic [FLD_W-1:0] ival_next      [CH_N];
    logic [FLD_W-1:0] phase_reg      [CH_N];
    logic [FLD_W-1:0] phase_next     [CH_N];
    logic [FLD_W-1:0] steps_reg, steps_next;
    logic [FLD_W-1:0] tick_reg, tick_next;
    logic             fade_active_reg, fade_active_next;
    logic             ticking_reg, ticking_next;
    logic [CH_IDX_W-1:0]  ch_reg, ch_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;

    // duty datapath
    logic [FLD_W-1:0]  top_reg, top_next;
    logic [LVL_W-1:0]  lvl_sh_reg [CH_N];
    logic [LVL_W-1:0]  lvl_sh_next[CH_N];
    logic [PROD_W-1:0] prod_reg   [CH_N];
    logic [PROD_W-1:0] prod_next  [CH_N];
    logic [Q0_W-1:0]   q0_reg     [CH_N];
    logic [Q0_W-1:0]   q0_next    [CH_N];
    logic [FLD_W-1:0]  duty_reg   [CH_N];
    logic [FLD_W-1:0]  duty_next  [CH_N];

    // result register
    logic             result_valid_reg, result_valid_next;
    logic [FLD_W-1:0] out_duty_reg  [CH_N];
    logic [FLD_W-1:0] out_duty_next [CH_N];
    logic [LVL_W-1:0] out_level_reg [CH_N];
    logic [LVL_W-1:0] out_level_next[CH_N];
    logic             out_fading_reg, out_fading_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  item_fire;
    logic                  at_goal;
    logic [DIV_W-1:0]      t_wide;
    logic [DIV_W-1:0]      t_x1000;
    logic [LVL_W-1:0]      sel_goal;
    logic [LVL_W-1:0]      sel_now;
    logic [LVL_W-1:0]      sel_diff;
    logic [IVAL_NUM_W-1:0] ival_num;
    logic [FLD_W-1:0]      top_val;
    logic [FLD_W-1:0]      tick_inc;
    logic [FLD_W-1:0]      phase_inc [CH_N];
    logic [PROD_W:0]       d255_sum  [CH_N];
    logic [DIV_W-1:0]      d255_rem  [CH_N];
    logic [Q0_W-1:0]       d255_q    [CH_N];
    logic                  out_free;

    rgbfe_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;

    always_comb
    begin
        at_goal = 1'b1;
        for (int k = 0; k < CH_N; k++)
        begin
            if (level_now_reg[k] != level_goal_reg[k])
            begin
                at_goal = 1'b0;
            end
        end

        // t*1000 = t*1024 - t*16 - t*8
        t_wide  = DIV_W'(fade_time_ms);
        t_x1000 = (t_wide << 10) - (t_wide << 4) - (t_wide << 3);

        sel_goal = level_goal_reg[ch_reg];
        sel_now  = level_now_reg[ch_reg];
        sel_diff = (sel_goal > sel_now) ? (sel_goal - sel_now) : (sel_now - sel_goal);
        ival_num = {1'b0, steps_reg, 1'b0} + IVAL_NUM_W'(sel_diff);

        top_val  = (period_reg != '0) ? (period_reg - 1'b1) : '0;
        tick_inc = tick_reg + 1'b1;

        for (int k = 0; k < CH_N; k++)
        begin
            phase_inc[k] = phase_reg[k] + 1'b1;
            // x/255 ~ (x + x/256 + x/65536)/256, low by at most one
            d255_sum[k]  = {1'b0, prod_reg[k]} + (PROD_W+1)'(prod_reg[k] >> 8)
                         + (PROD_W+1)'(prod_reg[k] >> 16);
            d255_rem[k]  = DIV_W'(prod_reg[k]) + DIV_W'(q0_reg[k])
                         - (DIV_W'(q0_reg[k]) << 8);
            d255_q[k]    = q0_reg[k] + Q0_W'(d255_rem[k] >= DIV_W'(255));
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        freq_next         = freq_reg;
        period_next       = period_reg;
        steps_next        = steps_reg;
        tick_next         = tick_reg;
        fade_active_next  = fade_active_reg;
        ticking_next      = ticking_reg;
        ch_next           = ch_reg;
        mul_cnt_next      = mul_cnt_reg;
        top_next          = top_reg;
        result_valid_next = result_valid_reg && !result_ready;
        out_fading_next   = out_fading_reg;
        level_now_next    = level_now_reg;
        level_goal_next   = level_goal_reg;
        ival_next         = ival_reg;
        phase_next        = phase_reg;
        lvl_sh_next       = lvl_sh_reg;
        prod_next         = prod_reg;
        q0_next           = q0_reg;
        duty_next         = duty_reg;
        out_duty_next     = out_duty_reg;
        out_level_next    = out_level_reg;

        div_req           = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_FREQUENCY: freq_next   = cfg_data;
                CFG_PWM_PERIOD:    period_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    if (cmd == CMD_SET_COLOUR)
                    begin
                        level_goal_next[0] = target_red;
                        level_goal_next[1] = target_green;
                        level_goal_next[2] = target_blue;
                        tick_next          = '0;
                        fade_active_next   = 1'b0;
                        ticking_next       = 1'b1;
                        div_req.start      = 1'b1;
                        div_req.dividend   = t_x1000;
                        div_req.divisor    = freq_reg;
                        div_req.iters      = STEPS_ITERS;
                        state_next         = S_STEPS;
                    end
                    else if (!ticking_reg)
                    begin
                        state_next = S_MUL_LOAD;
                    end
                    else if (steps_reg != '0 && !at_goal)
                    begin
                        if (!fade_active_reg)
                        begin
                            tick_next        = '0;
                            fade_active_next = 1'b1;
                            ch_next          = '0;
                            for (int k = 0; k < CH_N; k++)
                            begin
                                phase_next[k] = '0;
                            end
                            state_next = S_IVAL_SET;
                        end
                        else
                        begin
                            state_next = S_TICK;
                        end
                    end
                    else
                    begin
                        level_now_next   = level_goal_reg;
                        fade_active_next = 1'b0;
                        ticking_next     = 1'b0;
                        state_next       = S_MUL_LOAD;
                    end
                end
            end

            S_STEPS:
            begin
                // a zero frequency divides to all ones and caps to zero
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DIV_W'(freq_reg))
                    begin
                        steps_next = freq_reg;
                    end
                    else
                    begin
                        steps_next = div_rsp.quotient[FLD_W-1:0];
                    end
                    state_next = S_MUL_LOAD;
                end
            end

            S_IVAL_SET:
            begin
                if (sel_diff == '0 || FLD_W'(sel_diff) >= steps_reg)
                begin
                    ival_next[ch_reg] = (sel_diff == '0) ? '0 : FLD_W'(1);
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {ival_num, (DIV_W-IVAL_NUM_W)'(0)};
                    div_req.divisor  = DIV_REM_W'({sel_diff, 1'b0});
                    div_req.iters    = IVAL_ITERS;
                    state_next       = S_IVAL_DIV;
                end
            end

            S_IVAL_DIV:
            begin
                if (div_rsp.done)
                begin
                    ival_next[ch_reg] = div_rsp.quotient[FLD_W-1:0];
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_IVAL_SET;
                    end
                end
            end

            S_TICK:
            begin
                tick_next = tick_inc;
                // phase tracks tick_count mod interval without a divider
                for (int k = 0; k < CH_N; k++)
                begin
                    if (ival_reg[k] != '0)
                    begin
                        if (phase_inc[k] == ival_reg[k])
                        begin
                            phase_next[k] = '0;
                            if (level_goal_reg[k] > level_now_reg[k])
                            begin
                                level_now_next[k] = level_now_reg[k] + 1'b1;
                            end
                            else if (level_goal_reg[k] < level_now_reg[k])
                            begin
                                level_now_next[k] = level_now_reg[k] - 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next[k] = phase_inc[k];
                        end
                    end
                end
                if (tick_inc >= steps_reg)
                begin
                    level_now_next   = level_goal_reg;
                    fade_active_next = 1'b0;
                end
                state_next = S_MUL_LOAD;
            end

            S_MUL_LOAD:
            begin
                top_next     = top_val;
                mul_cnt_next = '1;
                for (int k = 0; k < CH_N; k++)
                begin
                    lvl_sh_next[k] = level_now_reg[k];
                    prod_next[k]   = '0;
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                // MSB first shift-add, one level bit per cycle
                for (int k = 0; k < CH_N; k++)
                begin
                    prod_next[k]   = (prod_reg[k] << 1)
                                   + (lvl_sh_reg[k][LVL_W-1] ? PROD_W'(top_reg) : '0);
                    lvl_sh_next[k] = lvl_sh_reg[k] << 1;
                end
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == '0)
                begin
                    state_next = S_D255A;
                end
            end

            S_D255A:
            begin
                for (int k = 0; k < CH_N; k++)
                begin
                    q0_next[k] = d255_sum[k][PROD_W:8];
                end
                state_next = S_D255B;
            end

            S_D255B:
            begin
                for (int k = 0; k < CH_N; k++)
                begin
                    duty_next[k] = FLD_W'(d255_q[k]) + 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_duty_next     = duty_reg;
                    out_level_next    = level_now_reg;
                    out_fading_next   = fade_active_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            freq_reg         <= PWM_FREQUENCY_RST;
            period_reg       <= PWM_PERIOD_RST;
            steps_reg        <= '0;
            tick_reg         <= '0;
            fade_active_reg  <= 1'b0;
            ticking_reg      <= 1'b0;
            ch_reg           <= '0;
            mul_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < CH_N; k++)
            begin
                level_now_reg[k]  <= '0;
                level_goal_reg[k] <= '0;
                ival_reg[k]       <= '0;
                phase_reg[k]      <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            freq_reg         <= freq_next;
            period_reg       <= period_next;
            steps_reg        <= steps_next;
            tick_reg         <= tick_next;
            fade_active_reg  <= fade_active_next;
            ticking_reg      <= ticking_next;
            ch_reg           <= ch_next;
            mul_cnt_reg      <= mul_cnt_next;
            result_valid_reg <= result_valid_next;
            level_now_reg    <= level_now_next;
            level_goal_reg   <= level_goal_next;
            ival_reg         <= ival_next;
            phase_reg        <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        lvl_sh_reg     <= lvl_sh_next;
        prod_reg       <= prod_next;
        q0_reg         <= q0_next;
        duty_reg       <= duty_next;
        out_duty_reg   <= out_duty_next;
        out_level_reg  <= out_level_next;
        out_fading_reg <= out_fading_next;
    end

    assign result_valid  = result_valid_reg;
    assign duty_red      = out_duty_reg[0];
    assign duty_green    = out_duty_reg[1];
    assign duty_blue     = out_duty_reg[2];
    assign current_red   = out_level_reg[0];
    assign current_green = out_level_reg[1];
    assign current_blue  = out_level_reg[2];
    assign fading        = out_fading_reg;

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_STEPS || state_reg == S_IVAL_DIV))
        else $error("divider finished with no divide pending");

    a_fade_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        fade_active_reg |-> ticking_reg)
        else $error("fade active while ticking is disarmed");

    a_fade_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fade_active_reg |-> (tick_reg < steps_reg))
        else $error("fade still active at or past its step count");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the result stage");

endmodule

`default_nettype wire
